FILE: hdl/ghalloc_pkg.sv
// ----------------------------------------------------------------------------
// ghalloc_pkg
// Shared types and codes of the generational handle allocator.
// ----------------------------------------------------------------------------
package ghalloc_pkg;

  // Widest index and generation a handle can carry
  localparam int IDX_MAX_W = 24;
  localparam int GEN_MAX_W = 8;

  // Operation codes
  localparam logic [1:0] FUNC_CREATE  = 2'd0;
  localparam logic [1:0] FUNC_DESTROY = 2'd1;
  localparam logic [1:0] FUNC_ALIVE   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

  // Register map (word index taken from paddr[2])
  localparam logic REG_MIN_FREE = 1'b0;

  localparam int          MIN_FREE_W     = 13;
  localparam logic [12:0] MIN_FREE_RESET = 13'd1024;

  // Command beat
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] handle_in;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [31:0] handle_out;
    logic        is_alive;
    logic [1:0]  status;
  } rsp_t;

  // What the table stage has to do with an issued command
  typedef enum logic [2:0] {
    K_REPORT,   // status only, no table access
    K_POP,      // reuse index read from the free FIFO
    K_NEW,      // fresh slot, generation 0
    K_DESTROY,  // bump generation
    K_ALIVE     // compare generation
  } kind_t;

  // Issue stage to table stage
  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [IDX_MAX_W-1:0] idx;
    logic [GEN_MAX_W-1:0] hgen;
    logic [1:0]           status;
  } issue_t;

endpackage

FILE: hdl/ghalloc_ram.sv
// ----------------------------------------------------------------------------
// ghalloc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ghalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/ghalloc_issue.sv
// ----------------------------------------------------------------------------
// ghalloc_issue
// Accepts commands, decides each one against the slot and FIFO counters,
// and drives the free-index FIFO.
// ----------------------------------------------------------------------------
module ghalloc_issue #(
  parameter int TABLE_DEPTH = 4096,
  parameter int INDEX_BITS  = 24,
  parameter int GEN_BITS    = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                acc,
  input  ghalloc_pkg::cmd_t                   cmd,
  input  logic [ghalloc_pkg::MIN_FREE_W-1:0]  min_free,
  output ghalloc_pkg::issue_t                 iss,
  output logic [$clog2(TABLE_DEPTH)-1:0]      fifo_rdata
);

  localparam int          AW       = $clog2(TABLE_DEPTH);
  localparam int          CW       = AW + 1;
  localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [31:0] DEPTH_W  = 32'(TABLE_DEPTH);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] slots_used, slots_used_next;

  ghalloc_pkg::issue_t iss_next;

  logic [31:0] hidx;
  logic [31:0] count_w;
  logic        in_range;
  logic        fifo_re, fifo_we;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(TABLE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign hidx     = (cmd.handle_in >> GEN_BITS) & IDX_MASK;
  assign count_w  = 32'(count);
  assign in_range = hidx < 32'(slots_used);

  // Decide the command
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    slots_used_next = slots_used;
    fifo_re         = 1'b0;
    fifo_we         = 1'b0;
    iss_next.valid  = acc;
    iss_next.kind   = ghalloc_pkg::K_REPORT;
    iss_next.idx    = '0;
    iss_next.hgen   = ghalloc_pkg::GEN_MAX_W'(cmd.handle_in[GEN_BITS-1:0]);
    iss_next.status = ghalloc_pkg::ST_OK;
    if (acc) begin
      case (cmd.func)
        ghalloc_pkg::FUNC_CREATE: begin
          if (count_w > 32'(min_free)) begin
            iss_next.kind = ghalloc_pkg::K_POP;
            fifo_re       = 1'b1;
          end else if (32'(slots_used) < DEPTH_W) begin
            iss_next.kind   = ghalloc_pkg::K_NEW;
            iss_next.idx    = ghalloc_pkg::IDX_MAX_W'(slots_used);
            slots_used_next = slots_used + 1'b1;
          end else if (count != '0) begin
            iss_next.kind = ghalloc_pkg::K_POP;
            fifo_re       = 1'b1;
          end else begin
            iss_next.status = ghalloc_pkg::ST_FULL;
          end
        end
        ghalloc_pkg::FUNC_DESTROY: begin
          if (!in_range) begin
            iss_next.status = ghalloc_pkg::ST_NOT_ALLOC;
          end else begin
            iss_next.kind = ghalloc_pkg::K_DESTROY;
            iss_next.idx  = ghalloc_pkg::IDX_MAX_W'(hidx);
            // push dropped when the FIFO is full
            if (count_w < DEPTH_W) begin
              fifo_we = 1'b1;
            end
          end
        end
        ghalloc_pkg::FUNC_ALIVE: begin
          if (!in_range) begin
            iss_next.status = ghalloc_pkg::ST_NOT_ALLOC;
          end else begin
            iss_next.kind = ghalloc_pkg::K_ALIVE;
            iss_next.idx  = ghalloc_pkg::IDX_MAX_W'(hidx);
          end
        end
        default: begin
          iss_next.kind = ghalloc_pkg::K_REPORT;
        end
      endcase
      if (fifo_re) begin
        head_next  = wrap_inc(head);
        count_next = count - 1'b1;
      end
      if (fifo_we) begin
        tail_next  = wrap_inc(tail);
        count_next = count + 1'b1;
      end
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      slots_used <= CW'(1);
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      slots_used <= slots_used_next;
    end
  end

  // Issue register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      iss.valid <= 1'b0;
    end else begin
      iss.valid <= iss_next.valid;
    end
    iss.kind   <= iss_next.kind;
    iss.idx    <= iss_next.idx;
    iss.hgen   <= iss_next.hgen;
    iss.status <= iss_next.status;
  end

  // Free-index FIFO
  ghalloc_ram #(
    .WIDTH (AW),
    .DEPTH (TABLE_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail),
    .wdata (hidx[AW-1:0]),
    .re    (fifo_re),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH_W)
    else $error("free FIFO count past depth");

  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used != '0 && 32'(slots_used) <= DEPTH_W)
    else $error("slot count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    fifo_re |-> count != '0 && !fifo_we)
    else $error("pop from empty FIFO or pop with push");

endmodule

FILE: hdl/ghalloc_lookup.sv
// ----------------------------------------------------------------------------
// ghalloc_lookup
// Generation table: read, forward the last write, update, form the result.
// ----------------------------------------------------------------------------
module ghalloc_lookup #(
  parameter int TABLE_DEPTH = 4096,
  parameter int INDEX_BITS  = 24,
  parameter int GEN_BITS    = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ghalloc_pkg::issue_t             iss,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  fifo_rdata,
  output logic                            done,
  output ghalloc_pkg::rsp_t               rsp
);

  localparam int          AW       = $clog2(TABLE_DEPTH);
  localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);

  ghalloc_pkg::issue_t s2;
  ghalloc_pkg::rsp_t   rsp_next;

  logic [AW-1:0]       idx1;
  logic                gen_re;
  logic [AW-1:0]       a2;
  logic [GEN_BITS-1:0] g_ram, g_cur, g_out;
  logic                gen_we;
  logic [GEN_BITS-1:0] gen_wdata;

  // Last table write, not yet visible to a read issued at the same edge
  logic                lw_valid;
  logic [AW-1:0]       lw_addr;
  logic [GEN_BITS-1:0] lw_data;
  // Slot 0 is live from reset with generation 0
  logic                slot0_written;

  // Index for the table read
  assign idx1   = (iss.kind == ghalloc_pkg::K_POP) ? fifo_rdata : iss.idx[AW-1:0];
  assign gen_re = iss.valid && (iss.kind == ghalloc_pkg::K_POP ||
                                iss.kind == ghalloc_pkg::K_DESTROY ||
                                iss.kind == ghalloc_pkg::K_ALIVE);

  // Table stage register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= iss.valid;
    end
    s2.kind   <= iss.kind;
    s2.idx    <= ghalloc_pkg::IDX_MAX_W'(idx1);
    s2.hgen   <= iss.hgen;
    s2.status <= iss.status;
  end

  ghalloc_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (a2),
    .wdata (gen_wdata),
    .re    (gen_re),
    .raddr (idx1),
    .rdata (g_ram)
  );

  assign a2 = s2.idx[AW-1:0];

  // Current generation with forwarding
  always_comb begin
    if (lw_valid && lw_addr == a2) begin
      g_cur = lw_data;
    end else if (!slot0_written && a2 == '0) begin
      g_cur = '0;
    end else begin
      g_cur = g_ram;
    end
  end

  assign gen_we    = s2.valid && (s2.kind == ghalloc_pkg::K_NEW ||
                                  s2.kind == ghalloc_pkg::K_DESTROY);
  assign gen_wdata = (s2.kind == ghalloc_pkg::K_NEW) ? '0 : g_cur + 1'b1;
  assign g_out     = (s2.kind == ghalloc_pkg::K_NEW) ? '0 : g_cur;

  // Result
  always_comb begin
    rsp_next.handle_out = '0;
    rsp_next.is_alive   = 1'b0;
    rsp_next.status     = s2.status;
    case (s2.kind)
      ghalloc_pkg::K_POP, ghalloc_pkg::K_NEW: begin
        rsp_next.handle_out = ((32'(a2) & IDX_MASK) << GEN_BITS) | 32'(g_out);
      end
      ghalloc_pkg::K_ALIVE: begin
        rsp_next.is_alive = (g_cur == s2.hgen[GEN_BITS-1:0]);
      end
      default: begin
        rsp_next.handle_out = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      lw_valid      <= 1'b0;
      slot0_written <= 1'b0;
    end else begin
      done     <= s2.valid;
      lw_valid <= gen_we;
      if (gen_we && a2 == '0) begin
        slot0_written <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp     <= rsp_next;
    lw_addr <= a2;
    lw_data <= gen_wdata;
  end

  // Checks
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ghalloc_pkg::ST_OK |-> rsp.handle_out == '0 && !rsp.is_alive)
    else $error("error result carries a handle or alive flag");

endmodule

FILE: hdl/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Hands out index/generation handles, retires them through a free-index
// FIFO and answers liveness checks.
//
//   channel | ports                                   | beat taken when
//   --------+-----------------------------------------+-----------------------
//   command | start, busy, cmd (func, handle_in)      | start && !busy
//   result  | done, rsp (handle_out, is_alive, status)| every cycle done is high
//   config  | psel, penable, pwrite, paddr, pwdata,   | psel && penable &&
//           | prdata, pready                          | pwrite && pready
//
// One command per cycle while busy is low. A command passes the issue register,
// the table stage register and the result register, behind the two registered
// RAM reads (free FIFO, then the generation table), with the last table write
// forwarded into the compare. busy is high in reset and in the cycle after it.
// Synchronous reset, no clearing pass: slot 0 reads as generation 0 until first
// written. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit #(
  parameter int TABLE_DEPTH = 4096,
  parameter int INDEX_BITS  = 24,
  parameter int GEN_BITS    = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ghalloc_pkg::cmd_t cmd,
  output logic              done,
  output ghalloc_pkg::rsp_t rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic                               acc;
  logic [ghalloc_pkg::MIN_FREE_W-1:0] min_free;
  ghalloc_pkg::issue_t                iss;
  logic [AW-1:0]                      fifo_rdata;

  assign acc = start && !busy;

  // Held off in reset and in the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ghalloc_pkg::REG_MIN_FREE) ? 32'(min_free) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_free <= ghalloc_pkg::MIN_FREE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ghalloc_pkg::REG_MIN_FREE) begin
      min_free <= pwdata[ghalloc_pkg::MIN_FREE_W-1:0];
    end
  end

  ghalloc_issue #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS),
    .GEN_BITS    (GEN_BITS)
  ) u_issue (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .cmd        (cmd),
    .min_free   (min_free),
    .iss        (iss),
    .fifo_rdata (fifo_rdata)
  );

  ghalloc_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS),
    .GEN_BITS    (GEN_BITS)
  ) u_lookup (
    .clk        (clk),
    .rst        (rst),
    .iss        (iss),
    .fifo_rdata (fifo_rdata),
    .done       (done),
    .rsp        (rsp)
  );

  // Checks
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a command three cycles back");

endmodule

FILE: test/generational_handle_allocator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit_test
// Self-checking bench for the handle allocator. A short table of directed
// commands comes first, then random traffic under several min_free settings,
// including one at the table depth. A predictor mirrors the generation
// table and the free FIFO, and each result beat is compared with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit_test;

  localparam int TABLE_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RSP_LATENCY = 3;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [2:0] MIN_FREE_ADDR = {ghalloc_pkg::REG_MIN_FREE, 2'b00};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  ghalloc_pkg::cmd_t cmd = '0;
  logic              done;
  ghalloc_pkg::rsp_t rsp;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  generational_handle_allocator_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_BITS (24),
    .GEN_BITS   (8)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .rsp    (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // Mirror of the allocator state
  logic [7:0]  gen_mirror [TABLE_DEPTH];
  int          free_mirror [$];
  int          slots_mirror = 1;
  logic [12:0] min_free_mirror = ghalloc_pkg::MIN_FREE_RESET;

  // Predicted result beats, oldest first
  ghalloc_pkg::rsp_t pending_rsp [$];

  int mismatches = 0;
  int cycles = 0;
  int cmds_sent = 0;
  int rsps_checked = 0;
  int readbacks = 0;
  int reuses = 0;
  int full_reports = 0;
  int dropped_pushes = 0;
  int gen_wraps = 0;
  int not_alloc_reports = 0;
  bit steady = 1'b0;

  function automatic void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", what);
  endfunction

  // Predict the result of one accepted command and advance the mirror
  function automatic ghalloc_pkg::rsp_t predict_rsp(input logic [1:0] f,
                                                    input logic [31:0] h);
    ghalloc_pkg::rsp_t r;
    logic [23:0]       idx;
    int                n;
    r = '0;
    idx = h[31:8];
    case (f)
      ghalloc_pkg::FUNC_CREATE: begin
        if (free_mirror.size() > int'(min_free_mirror) ||
            (slots_mirror >= TABLE_DEPTH && free_mirror.size() > 0)) begin
          n = free_mirror.pop_front();
          reuses++;
          r.handle_out = {n[23:0], gen_mirror[n]};
        end else if (slots_mirror < TABLE_DEPTH) begin
          n = slots_mirror;
          gen_mirror[n] = '0;
          slots_mirror++;
          r.handle_out = {n[23:0], 8'h00};
        end else begin
          r.status = ghalloc_pkg::ST_FULL;
          full_reports++;
        end
      end
      ghalloc_pkg::FUNC_DESTROY: begin
        if (int'(idx) >= slots_mirror) begin
          r.status = ghalloc_pkg::ST_NOT_ALLOC;
          not_alloc_reports++;
        end else begin
          gen_mirror[idx] = gen_mirror[idx] + 8'd1;
          if (gen_mirror[idx] == 8'd0) gen_wraps++;
          if (free_mirror.size() < TABLE_DEPTH) free_mirror.push_back(int'(idx));
          else dropped_pushes++;
        end
      end
      ghalloc_pkg::FUNC_ALIVE: begin
        if (int'(idx) >= slots_mirror) begin
          r.status = ghalloc_pkg::ST_NOT_ALLOC;
          not_alloc_reports++;
        end else begin
          r.is_alive = (gen_mirror[idx] == h[7:0]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Handle of a slot in use; stale generation when fresh is clear
  function automatic logic [31:0] pick_handle(input bit fresh);
    int idx;
    idx = $urandom_range(0, slots_mirror - 1);
    return {idx[23:0], fresh ? gen_mirror[idx] : 8'($urandom)};
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, pending_rsp.size());
      $display("generational_handle_allocator_unit: mismatch");
      $finish;
    end
  end

  // Result monitor: every done cycle is one beat
  always @(posedge clk) begin
    ghalloc_pkg::rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        flag_mismatch($sformatf("result beat %h with nothing due", rsp));
      end else begin
        want = pending_rsp.pop_front();
        rsps_checked++;
        if (rsp !== want)
          flag_mismatch($sformatf(
            "beat %0d: handle_out %h/%h is_alive %b/%b status %0d/%0d (exp/act)",
            rsps_checked, want.handle_out, rsp.handle_out, want.is_alive,
            rsp.is_alive, want.status, rsp.status));
      end
    end
  end

  // Send one command beat and predict its result once it is taken
  task automatic issue_cmd(input logic [1:0] f, input logic [31:0] h);
    if (!steady && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= '{func: f, handle_in: h};
    do @(posedge clk); while (busy);
    pending_rsp.push_back(predict_rsp(f, h));
    cmds_sent++;
  endtask

  task automatic random_cmd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      issue_cmd(ghalloc_pkg::FUNC_CREATE, $urandom);
    else if (pick < 70)
      issue_cmd(ghalloc_pkg::FUNC_DESTROY, $urandom_range(0, 19) == 0 ? $urandom :
                pick_handle($urandom_range(0, 9) != 0));
    else if (pick < 95)
      issue_cmd(ghalloc_pkg::FUNC_ALIVE, $urandom_range(0, 19) == 0 ? $urandom :
                pick_handle($urandom_range(0, 3) != 0));
    else
      issue_cmd(2'($urandom), $urandom);
  endtask

  // Wait until every result is in, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (RSP_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_min_free(input logic [31:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= MIN_FREE_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    min_free_mirror = value[12:0];
  endtask

  // Read back min_free; data is sampled mid access phase
  task automatic check_min_free();
    logic [31:0] got;
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= MIN_FREE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    readbacks++;
    if (got !== {19'd0, min_free_mirror})
      flag_mismatch($sformatf("min_free read %h, expected %h", got, min_free_mirror));
  endtask

  // Directed commands; typed rows carry an expectation read off by hand
  typedef struct packed {
    logic [1:0]        func;
    logic [31:0]       handle;
    logic              typed;
    ghalloc_pkg::rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows [17] = '{
    // slot 0 live
    '{ghalloc_pkg::FUNC_ALIVE, 32'h0000_0000, 1'b1,
      '{32'h0, 1'b1, ghalloc_pkg::ST_OK}},
    '{ghalloc_pkg::FUNC_ALIVE, 32'h0000_0001, 1'b1,
      '{32'h0, 1'b0, ghalloc_pkg::ST_OK}},
    '{ghalloc_pkg::FUNC_DESTROY, 32'h0000_0100, 1'b1,
      '{32'h0, 1'b0, ghalloc_pkg::ST_NOT_ALLOC}},
    '{ghalloc_pkg::FUNC_ALIVE, 32'hFFFF_FFFF, 1'b1,
      '{32'h0, 1'b0, ghalloc_pkg::ST_NOT_ALLOC}},
    '{ghalloc_pkg::FUNC_DESTROY, 32'hFFFF_FFFF, 1'b1,
      '{32'h0, 1'b0, ghalloc_pkg::ST_NOT_ALLOC}},
    // stray bits
    '{ghalloc_pkg::FUNC_CREATE, 32'hFFFF_FFFF, 1'b1,
      '{32'h100, 1'b0, ghalloc_pkg::ST_OK}},
    '{ghalloc_pkg::FUNC_CREATE, 32'h0000_0000, 1'b1,
      '{32'h200, 1'b0, ghalloc_pkg::ST_OK}},
    '{ghalloc_pkg::FUNC_ALIVE, 32'h0000_0100, 1'b1,
      '{32'h0, 1'b1, ghalloc_pkg::ST_OK}},
    '{ghalloc_pkg::FUNC_DESTROY, 32'h0000_0100, 1'b1,
      '{32'h0, 1'b0, ghalloc_pkg::ST_OK}},
    // stale
    '{ghalloc_pkg::FUNC_ALIVE, 32'h0000_0100, 1'b1,
      '{32'h0, 1'b0, ghalloc_pkg::ST_OK}},
    '{ghalloc_pkg::FUNC_ALIVE, 32'h0000_0101, 1'b1,
      '{32'h0, 1'b1, ghalloc_pkg::ST_OK}},
    // again
    '{ghalloc_pkg::FUNC_DESTROY, 32'h0000_0101, 1'b1,
      '{32'h0, 1'b0, ghalloc_pkg::ST_OK}},
    '{FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1,
      '{32'h0, 1'b0, ghalloc_pkg::ST_OK}},
    // below min_free
    '{ghalloc_pkg::FUNC_CREATE, 32'h0000_0000, 1'b1,
      '{32'h300, 1'b0, ghalloc_pkg::ST_OK}},
    '{ghalloc_pkg::FUNC_DESTROY, 32'h0000_0000, 1'b1,
      '{32'h0, 1'b0, ghalloc_pkg::ST_OK}},
    '{ghalloc_pkg::FUNC_ALIVE, 32'h0000_00FF, 1'b0, '0},
    '{ghalloc_pkg::FUNC_ALIVE, 32'h0000_0300, 1'b0, '0}
  };

  initial begin
    gen_mirror[0] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_min_free();

    // Directed table at reset settings
    foreach (dir_rows[i]) begin
      issue_cmd(dir_rows[i].func, dir_rows[i].handle);
      if (dir_rows[i].typed) pending_rsp[$] = dir_rows[i].want;
    end

    // Immediate reuse, with a gap-free stretch in the middle
    write_min_free(32'd0);
    check_min_free();
    for (int i = 0; i < 120; i++) begin
      steady = (i >= 40 && i < 80);
      random_cmd();
    end
    steady = 1'b0;

    // Stray upper data bits leave min_free at 3
    write_min_free(32'hFFFF_E003);
    check_min_free();
    repeat (120) random_cmd();

    // min_free at the table depth: creates open new slots while any are left
    write_min_free(32'd4096);
    check_min_free();
    repeat (60) random_cmd();

    // Back to immediate reuse with a deeper FIFO
    write_min_free(32'd0);
    check_min_free();
    repeat (80) random_cmd();

    drain();
    $display("%0d commands sent, %0d result beats checked, %0d readbacks of min_free",
             cmds_sent, rsps_checked, readbacks);
    $display("%0d reuses, %0d full, %0d not allocated, %0d dropped pushes, %0d wraps",
             reuses, full_reports, not_alloc_reports, dropped_pushes, gen_wraps);
    if (mismatches == 0) begin
      $display("generational_handle_allocator_unit: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("generational_handle_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
